@@ src/srr_pkg.sv @@
// Shared widths and word types of the selective-repeat receive window.
package srr_pkg;

   localparam int SEQ_W   = 16;
   localparam int LEN_W   = 11;
   localparam int OFS_W   = 26;
   localparam int TOTAL_W = 16;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_number;
      logic [LEN_W-1:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic               send_ack;
      logic [SEQ_W-1:0]   ack_number;
      logic               store_payload;
      logic [OFS_W-1:0]   store_offset;
      logic [LEN_W-1:0]   store_length;
      logic [SEQ_W-1:0]   window_base;
      logic               transfer_done;
   } rsp_type;

endpackage

@@ src/selective_repeat_receiver.sv @@
// Selective-repeat receive window: top level with register port and output stage.
// A word is captured, evaluated, takes k base steps, then enters the output register;
// k runs 0..WINDOW, one step per mark-RAM read; req_stall holds until the result is taken.
// Reset: synchronous, active high; clears base and total, then sweeps the mark RAM
// one slot per cycle with req_stall high; register writes are taken throughout.
module selective_repeat_receiver #(
   parameter int WINDOW       = 16,
   parameter int PACKET_BYTES = 1024,
   parameter int SEQ_BITS     = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  srr_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output srr_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [srr_pkg::TOTAL_W-1:0] csr_data
);
   import srr_pkg::*;

   // total_packets register, written whenever the port offers a word
   logic [TOTAL_W-1:0] total_ff, total_in;

   // handoff from the window sequencer
   logic    res_valid;
   logic    res_ready;
   rsp_type res_data;

   // output stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    load;

   assign csr_ready = 1'b1;
   assign total_in  = (csr_valid && csr_ready) ? csr_data : total_ff;

   srr_window #(
      .WINDOW       (WINDOW),
      .PACKET_BYTES (PACKET_BYTES),
      .SEQ_BITS     (SEQ_BITS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .total_packets (total_ff),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res_data      (res_data)
   );

   // Take a new word when the stage is empty or its word leaves this cycle.
   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_in       = load ? res_data : rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a stored payload is always acknowledged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_payload |-> rsp_data.send_ack)
      else $error("store without acknowledgement");

   // nothing to store means zero offset and length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.store_payload |->
         (rsp_data.store_offset == '0) && (rsp_data.store_length == '0))
      else $error("offset or length set without store");

   // done flag tracks the base against the configured total
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.transfer_done == (rsp_data.window_base >= total_ff))
      else $error("transfer_done inconsistent with window_base");

   // the sequencer holds its result until the output stage takes it
   assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res_data))
      else $error("sequencer result dropped while output stage full");
`endif

endmodule

@@ src/srr_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-old on collision).
module srr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/srr_window.sv @@
// Window sequencer: classifies each packet, updates the mark ring and advances the base.
module srr_window #(
   parameter int WINDOW       = 16,
   parameter int PACKET_BYTES = 1024,
   parameter int SEQ_BITS     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  srr_pkg::req_type        req_data,
   input  logic [srr_pkg::TOTAL_W-1:0] total_packets,
   output logic                    res_valid,
   input  logic                    res_ready,
   output srr_pkg::rsp_type        res_data
);
   import srr_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int STEP_W = $clog2(WINDOW + 1);
   localparam int PB_W   = 17;
   localparam int PROD_W = SEQ_W + PB_W;

   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(WINDOW - 1);
   localparam logic [SLOT_W:0]    WIN_WIDE   = (SLOT_W + 1)'(WINDOW);
   localparam logic [STEP_W-1:0]  WIN_STEPS  = STEP_W'(WINDOW);
   localparam logic [SEQ_W:0]     WIN_SEQ    = (SEQ_W + 1)'(WINDOW);
   localparam logic [SEQ_W:0]     WIN_SPAN   = (SEQ_W + 1)'(WINDOW - 1);
   localparam logic [PB_W-1:0]    PB_VAL     = PB_W'(PACKET_BYTES);
   localparam logic [LEN_W-1:0]   PB_LEN     = LEN_W'(PACKET_BYTES);
   localparam logic [SEQ_W-1:0]   SEQ_MASK   =
      (SEQ_BITS >= SEQ_W) ? {SEQ_W{1'b1}} : SEQ_W'((64'd1 << SEQ_BITS) - 64'd1);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_EVAL    = 3'd2;
   localparam logic [2:0] ST_ADVANCE = 3'd3;
   localparam logic [2:0] ST_DONE    = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SEQ_W-1:0]  base_ff, base_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ack_ff, ack_in;
   logic              store_ff, store_in;
   logic [OFS_W-1:0]  ofs_ff, ofs_in;
   logic [LEN_W-1:0]  slen_ff, slen_in;

   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic              mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;
   logic              mem_rdata;

   logic [SEQ_W-1:0]  old_low;
   logic [SEQ_W:0]    cur_high;
   logic              in_range, is_old, is_cur;
   logic [SEQ_W-1:0]  seq_dist;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] seq_slot;
   logic [SLOT_W-1:0] slot_next;
   logic [PROD_W-1:0] product;
   logic              keep_going;

   srr_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW)
   ) u_marks (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      old_low   = ({1'b0, base_ff} >= WIN_SEQ) ? SEQ_W'({1'b0, base_ff} - WIN_SEQ) : '0;
      cur_high  = {1'b0, base_ff} + WIN_SPAN;
      in_range  = seq_ff < total_packets;
      is_old    = (seq_ff >= old_low) && (seq_ff < base_ff);
      is_cur    = (seq_ff >= base_ff) && ({1'b0, seq_ff} <= cur_high);
      seq_dist  = seq_ff - base_ff;
      slot_sum  = {1'b0, slot_ff} + {1'b0, seq_dist[SLOT_W-1:0]};
      seq_slot  = (slot_sum >= WIN_WIDE) ? SLOT_W'(slot_sum - WIN_WIDE) : slot_sum[SLOT_W-1:0];
      slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
      product   = {{PB_W{1'b0}}, seq_ff} * {{SEQ_W{1'b0}}, PB_VAL};
      keep_going = (steps_ff < WIN_STEPS) && (base_ff < total_packets) && mem_rdata;
   end

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      slot_in   = slot_ff;
      steps_in  = steps_ff;
      clr_in    = clr_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      ack_in    = ack_ff;
      store_in  = store_ff;
      ofs_in    = ofs_ff;
      slen_in   = slen_ff;
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = 1'b0;
      mem_raddr = slot_next;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               seq_in   = req_data.seq_number & SEQ_MASK;
               len_in   = req_data.payload_bytes;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ack_in   = in_range && (is_old || is_cur);
            store_in = in_range && is_cur;
            ofs_in   = '0;
            slen_in  = '0;
            state_in = ST_DONE;
            if (in_range && is_cur) begin
               ofs_in  = product[OFS_W-1:0];
               slen_in = ({{(PB_W - LEN_W){1'b0}}, len_ff} > PB_VAL) ? PB_LEN : len_ff;
               mem_we    = 1'b1;
               mem_waddr = seq_slot;
               if (seq_ff == base_ff) begin
                  // base slot is set and consumed at once: clear it and step
                  mem_wdata = 1'b0;
                  base_in   = base_ff + 1'b1;
                  slot_in   = slot_next;
                  steps_in  = STEP_W'(1);
                  state_in  = ST_ADVANCE;
               end else begin
                  mem_wdata = 1'b1;
               end
            end
         end
         ST_ADVANCE: begin
            if (keep_going) begin
               mem_we   = 1'b1;
               base_in  = base_ff + 1'b1;
               slot_in  = slot_next;
               steps_in = steps_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         base_ff  <= '0;
         slot_ff  <= '0;
         steps_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         slot_ff  <= slot_in;
         steps_ff <= steps_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      len_ff   <= len_in;
      ack_ff   <= ack_in;
      store_ff <= store_in;
      ofs_ff   <= ofs_in;
      slen_ff  <= slen_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res_data.send_ack      = ack_ff;
      res_data.ack_number    = seq_ff;
      res_data.store_payload = store_ff;
      res_data.store_offset  = ofs_ff;
      res_data.store_length  = slen_ff;
      res_data.window_base   = base_ff;
      res_data.transfer_done = (base_ff >= total_packets);
   end

endmodule

@@ verif/tb.sv @@
// Testbench for the selective-repeat receive window: directed and random packets, checked word by word.
`timescale 1ns / 1ps

module tb;
   import srr_pkg::*;

   localparam int WINDOW        = 16;
   localparam int PACKET_BYTES  = 1024;
   localparam int SEQ_BITS      = 16;
   localparam int IDLE_PCT      = 37;
   localparam int SETTLE_CYCLES = 2 + WINDOW + 8;   // covers the output path after a full base sweep
   localparam int QUIET_LIMIT   = 1000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SEQ_TOP       = (1 << SEQ_BITS) - 1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TOTAL_W-1:0]   csr_data  = '0;

   // Window model: register copy, base and ring of receive marks.
   logic [TOTAL_W-1:0]   total_pkts = '0;
   logic [SEQ_W-1:0]     win_base   = '0;
   bit                   marks [WINDOW];

   rsp_type              pending_replies [$];
   bit                   calm = 1'b0;        // no random idling on either side while set; held packets still wait
   int                   errors      = 0;
   int                   stored_cnt  = 0;
   int                   acked_cnt   = 0;
   int                   ignored_cnt = 0;
   int                   csr_writes  = 0;
   int                   longest_step = 0;
   int                   quiet_cycles = 0;

   selective_repeat_receiver #(
      .WINDOW(WINDOW),
      .PACKET_BYTES(PACKET_BYTES),
      .SEQ_BITS(SEQ_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the reply to one accepted packet and advance the window model.
   function automatic rsp_type predict_packet(input req_type word);
      rsp_type          r;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W:0]   old_low;
      logic [SEQ_W:0]   cur_high;
      int               steps;
      r        = '0;
      seq      = SEQ_W'(word.seq_number[SEQ_BITS-1:0]);
      old_low  = (win_base >= WINDOW) ? (SEQ_W+1)'(win_base - WINDOW) : '0;
      cur_high = (SEQ_W+1)'(win_base + WINDOW - 1);
      // Numbers at or past the transfer end are dropped outright.
      if (seq < total_pkts) begin
         if ({1'b0, seq} >= old_low && seq < win_base) begin
            r.send_ack = 1'b1;
         end else if (seq >= win_base && {1'b0, seq} <= cur_high) begin
            r.send_ack      = 1'b1;
            r.store_payload = 1'b1;
            marks[seq % WINDOW] = 1'b1;
            r.store_offset  = OFS_W'(32'(seq) * PACKET_BYTES);
            r.store_length  = (word.payload_bytes > PACKET_BYTES) ?
                              LEN_W'(PACKET_BYTES) : word.payload_bytes;
            // Slide the base over consecutive marks, clearing each.
            if (seq == win_base) begin
               steps = 0;
               while (steps < WINDOW && win_base < total_pkts && marks[win_base % WINDOW]) begin
                  marks[win_base % WINDOW] = 1'b0;
                  win_base++;
                  steps++;
               end
               if (steps > longest_step) longest_step = steps;
            end
         end
      end
      r.ack_number    = seq;
      r.window_base   = win_base;
      r.transfer_done = (win_base >= total_pkts);
      if (r.store_payload) stored_cnt++;
      else if (r.send_ack) acked_cnt++;
      else ignored_cnt++;
      return r;
   endfunction

   // Offer one packet; hold it until accepted, then queue its expected reply.
   // With hold set, drop valid and wait for every outstanding reply first.
   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                              input bit hold = 1'b0);
      req_type word;
      bit      dropped;
      word.seq_number    = seq;
      word.payload_bytes = len;
      dropped = 1'b0;
      if (hold) begin
         req_valid <= 1'b0;
         dropped = 1'b1;
         do @(posedge clock); while (pending_replies.size() != 0);
      end
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         if (!dropped) req_valid <= 1'b0;
         dropped = 1'b1;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (req_stall);
      pending_replies.push_back(predict_packet(word));
   endtask

   // Drop valid, drain all replies and let the block go quiet.
   task automatic settle_window();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_total(input logic [TOTAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      total_pkts = value;
      csr_writes++;
   endtask

   // Receiver side: stall at random except in calm stretches.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         errors++;
      end
   endtask

   // Check each accepted reply against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, got ack_number %0d",
                     $time, rsp_data.ack_number);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("send_ack", 32'(want.send_ack), 32'(rsp_data.send_ack));
            compare_field("ack_number", 32'(want.ack_number), 32'(rsp_data.ack_number));
            compare_field("store_payload", 32'(want.store_payload),
                          32'(rsp_data.store_payload));
            compare_field("store_offset", 32'(want.store_offset),
                          32'(rsp_data.store_offset));
            compare_field("store_length", 32'(want.store_length),
                          32'(rsp_data.store_length));
            compare_field("window_base", 32'(want.window_base), 32'(rsp_data.window_base));
            compare_field("transfer_done", 32'(want.transfer_done),
                          32'(rsp_data.transfer_done));
         end
      end
   end

   // Watchdog: end the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
                  $time, QUIET_LIMIT, pending_replies.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Reset value of the total is zero: every packet is dropped and the transfer reads done.
   task automatic test_empty_transfer();
      send_packet(16'd0, 11'd0);
      send_packet(16'hFFFF, 11'h7FF);
   endtask

   // Short transfer: early base, duplicates, saturated length, out-of-order slide to the end.
   task automatic test_small_transfer();
      settle_window();
      write_total(16'd6);
      send_packet(16'd0, 11'd1024);
      send_packet(16'd0, 11'd5);          // old window while base is still below WINDOW
      send_packet(16'd2, 11'h7FF);        // length clamps to one packet
      send_packet(16'd2, 11'd1);          // duplicate inside the window
      send_packet(16'd6, 11'd100);        // past the transfer end
      send_packet(16'd1, 11'd0, 1'b1);    // hold off until drained, then slide base to 3
      send_packet(16'd4, 11'd7);
      send_packet(16'd5, 11'd1025);
      send_packet(16'd3, 11'd300);        // slide over 3..5, stop at the total
      send_packet(16'd5, 11'd9);
   endtask

   // Largest total: top edge of the window, just past it, and the top sequence number.
   task automatic test_full_range_total();
      settle_window();
      write_total(16'hFFFF);
      send_packet(16'd21, 11'd512);
      send_packet(16'd22, 11'd3);
      send_packet(16'hFFFF, 11'h7FF);
      send_packet(16'd6, 11'd1024);
   endtask

   // Total written below the base: base holds, done reads high, old numbers still acked.
   task automatic test_lowered_total();
      settle_window();
      write_total(16'd3);
      send_packet(16'd7, 11'd64);
      send_packet(16'd2, 11'd64);
   endtask

   function automatic logic [SEQ_W-1:0] pick_seq();
      int roll;
      int v;
      roll = $urandom_range(99);
      if (roll < 70)      v = win_base + $urandom_range(0, WINDOW - 1);
      else if (roll < 80) v = win_base - $urandom_range(1, WINDOW);
      else if (roll < 85) v = win_base + WINDOW;
      else if (roll < 90) v = total_pkts + $urandom_range(0, 2) - 1;
      else                v = $urandom_range(0, SEQ_TOP);
      if (v < 0) v = 0;
      return SEQ_W'(v);
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) return LEN_W'($urandom_range(0, PACKET_BYTES));
      if (roll < 90) return LEN_W'($urandom_range(PACKET_BYTES + 1, (1 << LEN_W) - 1));
      case ($urandom_range(2))
         0:       return '0;
         1:       return LEN_W'(PACKET_BYTES);
         default: return '1;
      endcase
   endfunction

   // Phases of window traffic, each under a fresh total; one phase runs without random idling.
   task automatic test_random_traffic();
      int issued;
      int phase;
      int phase_len;
      int sent;
      int roll;
      int v;
      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         settle_window();
         roll = $urandom_range(99);
         if (roll < 10 && win_base > 0) v = $urandom_range(0, win_base - 1);
         else if (roll < 18)            v = SEQ_TOP;
         else                           v = win_base + $urandom_range(1, 300);
         if (v > SEQ_TOP) v = SEQ_TOP;
         write_total(TOTAL_W'(v));
         calm      = (phase == 3);
         phase_len = calm ? 200 : $urandom_range(30, 200);
         sent      = 0;
         // Stop once the transfer is done and 20 or more are sent; only acks of old numbers remain.
         while (sent < phase_len && issued < RANDOM_ITEMS &&
                !(win_base >= total_pkts && sent >= 20)) begin
            send_packet(pick_seq(), pick_len(), $urandom_range(99) < 2);
            issued++;
            sent++;
         end
         calm = 1'b0;
         phase++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_transfer();
      test_small_transfer();
      test_full_range_total();
      test_lowered_total();
      test_random_traffic();
      settle_window();
      $display("Covered %0d packets: %0d stored, %0d acked only, %0d dropped.",
               stored_cnt + acked_cnt + ignored_cnt, stored_cnt, acked_cnt, ignored_cnt);
      $display("Total written %0d times; base reached %0d, longest slide %0d slots.",
               csr_writes, win_base, longest_step);
      if (errors == 0 && pending_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d replies never arrived", errors, pending_replies.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/srr_pkg.sv
src/srr_ram.sv
src/srr_window.sv
src/selective_repeat_receiver.sv
verif/tb.sv
